/* rtl/b64d_pkg.sv */
`default_nettype none

package b64d_pkg;

  // Alphabet range bounds
  localparam logic [7:0] CharUpperA = 8'h41;  // 'A'
  localparam logic [7:0] CharUpperZ = 8'h5a;  // 'Z'
  localparam logic [7:0] CharLowerA = 8'h61;  // 'a'
  localparam logic [7:0] CharLowerZ = 8'h7a;  // 'z'
  localparam logic [7:0] CharDigit0 = 8'h30;  // '0'
  localparam logic [7:0] CharDigit9 = 8'h39;  // '9'
  localparam logic [7:0] CharPlus   = 8'h2b;  // '+'
  localparam logic [7:0] CharSlash  = 8'h2f;  // '/'

  localparam logic [5:0] LowerBase = 6'd26;
  localparam logic [5:0] DigitBase = 6'd52;
  localparam logic [5:0] PlusCode  = 6'd62;
  localparam logic [5:0] SlashCode = 6'd63;

  localparam logic [1:0] GroupFull = 2'd3;  // held sextets before the closing one

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // One queued request: up to three bytes, emitted data[0] first
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      cnt;         // results in this request, 1..3
    logic            byte_valid;
    logic            eom;
  } job_t;

  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t    s;
    logic [7:0] d;
    s = '0;
    d = '0;
    if (ch >= CharUpperA && ch <= CharUpperZ) begin
      d = ch - CharUpperA;
      s = '{ok: 1'b1, val: d[5:0]};
    end else if (ch >= CharLowerA && ch <= CharLowerZ) begin
      d = ch - CharLowerA;
      s = '{ok: 1'b1, val: d[5:0] + LowerBase};
    end else if (ch >= CharDigit0 && ch <= CharDigit9) begin
      d = ch - CharDigit0;
      s = '{ok: 1'b1, val: d[5:0] + DigitBase};
    end else if (ch == CharPlus) begin
      s = '{ok: 1'b1, val: PlusCode};
    end else if (ch == CharSlash) begin
      s = '{ok: 1'b1, val: SlashCode};
    end
    return s;
  endfunction

  // Four sextets -> three bytes, MSBs first
  function automatic logic [2:0][7:0] group_bytes(input logic [5:0] a, input logic [5:0] b,
                                                  input logic [5:0] c, input logic [5:0] d);
    logic [2:0][7:0] r;
    r[0] = {a, b[5:4]};
    r[1] = {b[3:0], c[5:2]};
    r[2] = {c[1:0], d};
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/base64_stream_decoder_unit.sv */
// Channel   Direction  Handshake            Payload
// input     in         push / full          symbol[7:0], end_marker
// result    out        empty / pop          data_byte[7:0], byte_valid, last_of_run,
//                                           end_of_message
//
// One character is taken per cycle while full is low; a character that closes a group
// or an end marker writes one request (up to three bytes) into the request queue.
// Results leave at one per cycle from the queue head while pop is high; the 3-byte group
// per 4 characters keeps the back end ahead of the front at full input rate.
// A request is registered into the queue and shows on the result ports once it reaches the head.
// Reset (rst, synchronous) clears the held group, the halt flag and the queue.
// full rises only when all QUEUE_DEPTH request slots are taken.
`default_nettype none

module base64_stream_decoder_unit #(
  parameter int QUEUE_DEPTH = 4  // request slots, >= 1
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] symbol,
  input  wire logic       end_marker,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      data_byte,
  output logic            byte_valid,
  output logic            last_of_run,
  output logic            end_of_message
);

  b64d_pkg::job_t job, head;
  logic           job_push, rd_en, q_full, q_empty, accept;

  assign accept = push && !q_full;
  assign full   = q_full;
  assign empty  = q_empty;

  // Front: sextet lookup, group assembly, halt tracking
  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .symbol     (symbol),
    .end_marker (end_marker),
    .job_push   (job_push),
    .job        (job)
  );

  // Requests waiting for the back end
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_job  (job),
    .rd_en   (rd_en),
    .head    (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // Back: walks the bytes of the head request, one per pop
  b64d_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_empty        (q_empty),
    .pop            (pop),
    .rd_en          (rd_en),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .last_of_run    (last_of_run),
    .end_of_message (end_of_message)
  );

endmodule

`default_nettype wire

/* rtl/b64d_front.sv */
`default_nettype none

module b64d_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      symbol,
  input  wire logic            end_marker,
  output logic                 job_push,
  output b64d_pkg::job_t       job
);

  logic [2:0][5:0]   hold, hold_next;
  logic [1:0]        count, count_next;
  logic              halted, halted_next;
  b64d_pkg::sextet_t sx;

  assign sx = b64d_pkg::sextet_of(symbol);

  always_comb begin
    hold_next   = hold;
    count_next  = count;
    halted_next = halted;
    job_push    = 1'b0;
    job         = '0;
    if (accept) begin
      if (end_marker) begin
        job_push = 1'b1;
        job.eom  = 1'b1;
        if (count >= 2'd2) begin
          job.data       = b64d_pkg::group_bytes(hold[0], hold[1],
                                                 (count == 2'd3) ? hold[2] : 6'd0, 6'd0);
          job.cnt        = count - 2'd1;
          job.byte_valid = 1'b1;
        end else begin
          job.cnt = 2'd1;  // lone marker result, no byte
        end
        hold_next   = '0;
        count_next  = '0;
        halted_next = 1'b0;
      end else if (!halted) begin
        if (!sx.ok) begin
          halted_next = 1'b1;
        end else if (count < b64d_pkg::GroupFull) begin
          hold_next[count] = sx.val;
          count_next       = count + 2'd1;
        end else begin
          job_push       = 1'b1;
          job.data       = b64d_pkg::group_bytes(hold[0], hold[1], hold[2], sx.val);
          job.cnt        = 2'd3;
          job.byte_valid = 1'b1;
          hold_next      = '0;
          count_next     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold   <= '0;
      count  <= '0;
      halted <= 1'b0;
    end else begin
      hold   <= hold_next;
      count  <= count_next;
      halted <= halted_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/b64d_queue.sv */
`default_nettype none

module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire b64d_pkg::job_t wr_job,
  input  wire logic           rd_en,
  output b64d_pkg::job_t      head,
  output logic                q_full,
  output logic                q_empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  b64d_pkg::job_t slots [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr, do_rd;

  assign q_full  = (count == CntW'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/b64d_back.sv */
`default_nettype none

module b64d_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire b64d_pkg::job_t head,
  input  wire logic           q_empty,
  input  wire logic           pop,
  output logic                rd_en,
  output logic [7:0]          data_byte,
  output logic                byte_valid,
  output logic                last_of_run,
  output logic                end_of_message
);

  logic [1:0] idx;
  logic       take;

  assign last_of_run    = (idx == head.cnt - 2'd1);
  assign data_byte      = head.data[idx];
  assign byte_valid     = head.byte_valid;
  assign end_of_message = head.eom && last_of_run;

  assign take  = pop && !q_empty;
  assign rd_en = take && last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= last_of_run ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

/* rtl/b64d_checker.sv */
`default_nettype none

module b64d_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] data_byte,
  input wire logic       byte_valid,
  input wire logic       last_of_run,
  input wire logic       end_of_message
);

  // A no-byte result only ever closes a message
  a_nobyte_is_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_valid) |-> (last_of_run && end_of_message && data_byte == 8'd0))
    else $error("no-byte result without end flags or with nonzero data");

  a_eom_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_of_message) |-> last_of_run)
    else $error("end_of_message without last_of_run");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("results visible right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(data_byte) && $stable(last_of_run)))
    else $error("stalled result changed");

endmodule

bind base64_stream_decoder_unit b64d_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .empty          (empty),
  .pop            (pop),
  .data_byte      (data_byte),
  .byte_valid     (byte_valid),
  .last_of_run    (last_of_run),
  .end_of_message (end_of_message)
);

`default_nettype wire

/* test/tb_base64_stream_decoder_unit.sv */
`default_nettype none

module tb_base64_stream_decoder_unit;

  // '=' closes the text early; anything outside the alphabet does the same
  localparam logic [7:0] PadChar = 8'h3d;
  // cycles with no request moving in either direction before we give up
  localparam int StallLimit = 4000;
  // idle cycles run after the last owed result has been checked
  localparam int DrainCycles = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       eom;
  } byte_result_t;

  // Mirrors the decoder state and keeps the results still owed by the block.
  class decode_board;
    logic [5:0]   held[3];
    logic [1:0]   held_count;
    logic         stopped;
    byte_result_t pending_bytes[$];
    int unsigned  mismatches;
    int unsigned  results_seen;
    int unsigned  bytes_seen;
    int unsigned  messages_seen;

    function new();
      clear_group();
      mismatches    = 0;
      results_seen  = 0;
      bytes_seen    = 0;
      messages_seen = 0;
    endfunction

    function void clear_group();
      held[0]    = '0;
      held[1]    = '0;
      held[2]    = '0;
      held_count = '0;
      stopped    = 1'b0;
    endfunction

    // One accepted input request: update state, queue the bytes it releases.
    function void decode_request(logic [7:0] sym, logic endm);
      logic [7:0] t;
      logic [5:0] v;
      logic [5:0] c;
      logic       ok;
      logic [7:0] b0, b1, b2;
      if (endm) begin
        messages_seen++;
        // missing sextets of a partial group count as zero
        c  = (held_count == 2'd3) ? held[2] : 6'd0;
        b0 = {held[0], held[1][5:4]};
        b1 = {held[1][3:0], c[5:2]};
        if (held_count == 2'd3) begin
          pending_bytes.push_back('{data: b0, valid: 1'b1, last: 1'b0, eom: 1'b0});
          pending_bytes.push_back('{data: b1, valid: 1'b1, last: 1'b1, eom: 1'b1});
        end else if (held_count == 2'd2) begin
          pending_bytes.push_back('{data: b0, valid: 1'b1, last: 1'b1, eom: 1'b1});
        end else begin
          // nothing to flush (a lone sextet makes no byte)
          pending_bytes.push_back('{data: 8'h00, valid: 1'b0, last: 1'b1, eom: 1'b1});
        end
        clear_group();
        return;
      end
      if (stopped) return;
      ok = 1'b1;
      t  = '0;
      if (sym >= b64d_pkg::CharUpperA && sym <= b64d_pkg::CharUpperZ)
        t = sym - b64d_pkg::CharUpperA;
      else if (sym >= b64d_pkg::CharLowerA && sym <= b64d_pkg::CharLowerZ)
        t = sym - b64d_pkg::CharLowerA + 8'd26;
      else if (sym >= b64d_pkg::CharDigit0 && sym <= b64d_pkg::CharDigit9)
        t = sym - b64d_pkg::CharDigit0 + 8'd52;
      else if (sym == b64d_pkg::CharPlus) t = 8'd62;
      else if (sym == b64d_pkg::CharSlash) t = 8'd63;
      else ok = 1'b0;
      v = t[5:0];
      if (!ok) begin
        stopped = 1'b1;
        return;
      end
      if (held_count != 2'd3) begin
        held[held_count] = v;
        held_count++;
        return;
      end
      b0 = {held[0], held[1][5:4]};
      b1 = {held[1][3:0], held[2][5:2]};
      b2 = {held[2][1:0], v};
      pending_bytes.push_back('{data: b0, valid: 1'b1, last: 1'b0, eom: 1'b0});
      pending_bytes.push_back('{data: b1, valid: 1'b1, last: 1'b0, eom: 1'b0});
      pending_bytes.push_back('{data: b2, valid: 1'b1, last: 1'b1, eom: 1'b0});
      clear_group();
    endfunction

    function void check_result(logic [7:0] d, logic v, logic l, logic e);
      byte_result_t got;
      byte_result_t want;
      got = '{data: d, valid: v, last: l, eom: e};
      results_seen++;
      if (v) bytes_seen++;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result data=%h valid=%b last=%b eom=%b",
                 $time, d, v, l, e);
        return;
      end
      want = pending_bytes.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: mismatch exp data=%h v=%b l=%b e=%b, got data=%h v=%b l=%b e=%b",
                 $time, want.data, want.valid, want.last, want.eom, d, v, l, e);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] symbol;
  logic       end_marker;
  logic       empty;
  logic       pop;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_of_run;
  logic       end_of_message;

  decode_board board;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          requests_sent;
  int          stall_cycles;
  string       b64_chars =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  base64_stream_decoder_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .symbol         (symbol),
    .end_marker     (end_marker),
    .empty          (empty),
    .pop            (pop),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .last_of_run    (last_of_run),
    .end_of_message (end_of_message)
  );

  // 2-unit period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sender: optional idle cycles, then hold the request until full is low at an edge.
  // Inputs are read right after the edge, so full is the value the block saw.
  task automatic send_request(input logic [7:0] s, input logic e);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    symbol     <= s;
    end_marker <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    board.decode_request(s, e);
    requests_sent++;
  endtask

  task automatic send_chars(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  // Random text. Most are well-formed: random sextets, usually padded to a full group.
  // The rest carry foreign bytes, odd lengths or trailing junk.
  task automatic send_message();
    int kind;
    int nbytes;
    int nchars;
    kind   = $urandom_range(0, 99);
    nbytes = $urandom_range(0, 9);
    nchars = (nbytes / 3) * 4 + ((nbytes % 3 != 0) ? nbytes % 3 + 1 : 0);
    if (kind >= 80) nchars = $urandom_range(0, 13);
    for (int i = 0; i < nchars; i++) begin
      if (kind >= 80 && $urandom_range(0, 5) == 0)
        send_request(8'($urandom_range(0, 255)), 1'b0);
      else
        send_request(b64_chars[$urandom_range(0, 63)], 1'b0);
    end
    if (kind < 80 && nbytes % 3 != 0 && $urandom_range(0, 7) != 0)
      repeat (3 - nbytes % 3) send_request(PadChar, 1'b0);
    if (kind >= 90)
      repeat ($urandom_range(1, 3)) send_request(8'($urandom_range(0, 255)), 1'b0);
    // symbol is don't-care on the end marker; drive it random anyway
    send_request(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Receiver: check what left at this edge, then pick pop for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) board.check_result(data_byte, byte_valid, last_of_run, end_of_message);
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: no request moving either way for too long means a hang.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles, %0d results still owed",
                 $time, StallLimit, board.pending_bytes.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    board         = new();
    rst           = 1'b1;
    push          = 1'b0;
    pop           = 1'b0;
    symbol        = '0;
    end_marker    = 1'b0;
    stall_cycles  = 0;
    requests_sent = 0;
    send_idle_pct = 38;
    recv_idle_pct = 83;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: end with nothing held, alphabet edges in full groups,
    // one/two/three held at the end, pad then ignored chars, foreign bytes
    send_request(8'hff, 1'b1);
    send_chars("AZaz");
    send_chars("09+/");
    send_request(8'h00, 1'b1);
    send_chars("Q");
    send_request(8'h41, 1'b1);
    send_chars("QU");
    send_request(8'h3d, 1'b1);
    send_chars("QUJ=");
    send_chars("x");
    send_request(8'h5a, 1'b1);
    send_request(8'h00, 1'b0);
    send_request(8'hff, 1'b0);
    send_request(8'h00, 1'b1);

    // random: slow receiver, then slow sender, then full rate both sides
    while (requests_sent < 140) send_message();
    send_idle_pct = 83;
    recv_idle_pct = 38;
    while (requests_sent < 255) send_message();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (requests_sent < 360) send_message();
    push <= 1'b0;

    while (board.pending_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d requests in %0d texts; checked %0d results (%0d bytes).",
             requests_sent, board.messages_seen, board.results_seen, board.bytes_seen);
    $display("Stall mixes: slow receiver, slow sender, none; pads, foreign bytes, partial groups.");
    if (board.mismatches == 0 && board.pending_bytes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results never seen",
               board.mismatches, board.pending_bytes.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
